@@ design/diff_drive_odometry_defines.svh @@
// Assertion macros used by the odometry top-level design file.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// Same-cycle implication checked on every clock edge out of reset.
`define DDO_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("odometry check failed");

// Next-cycle implication checked on every clock edge out of reset.
`define DDO_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("odometry check failed");

`endif

@@ design/ddo_pkg.sv @@
// Shared constants and the CORDIC arctangent table for the odometry block.
package ddo_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_RADIUS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_TRACK       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATERAL_VELOCITY = 2'd2;

   localparam int CORDIC_STEPS = 30;
   localparam int Q30_SHIFT    = 30;
   localparam longint Q30_PI      = 64'sd3373259426;
   localparam longint Q30_HALF_PI = 64'sd1686629713;
   localparam longint Q30_TWO_PI  = 64'sd6746518852;
   localparam longint Q30_GAIN    = 64'sd652032874;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ design/ddo_mul.sv @@
// Shared signed multiplier with a registered product.
module ddo_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic                       clock,
   input  logic signed [A_W-1:0]      mul_a,
   input  logic signed [B_W-1:0]      mul_b,
   output logic signed [A_W+B_W-1:0]  prod
);

   logic signed [A_W+B_W-1:0] prod_ff;
   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ design/ddo_div.sv @@
// Bit-serial restoring divider for the yaw rate, saturated to 32 bits.
module ddo_div #(
   parameter int NW = 43,
   parameter int DW = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NW-1:0]       dividend,
   input  logic [DW-1:0]       divisor,
   input  logic                negate,
   output logic                busy,
   output logic signed [31:0]  quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [DW:0]   shifted;
   logic          fits;

   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      shifted  = {rem_ff, quo_ff[NW-1]};
      fits     = shifted >= {1'b0, dvs_ff};
      if (start) begin
         count_in = CW'(NW);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         neg_in   = negate;
      end else if (count_ff != '0) begin
         // shift in one quotient bit
         rem_in   = fits ? DW'(shifted - {1'b0, dvs_ff}) : shifted[DW-1:0];
         quo_in   = {quo_ff[NW-2:0], fits};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy = count_ff != '0;

   always_comb begin
      if (neg_ff) begin
         quotient = (quo_ff > NW'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(quo_ff[31:0]);
      end else begin
         quotient = (quo_ff > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo_ff[31:0]);
      end
   end

endmodule

@@ design/ddo_cordic.sv @@
// Iterative CORDIC: range reduction, quadrant fold and 30 rotations for cos/sin.
module ddo_cordic #(
   parameter int FRAC_BITS = 16,
   parameter int AW        = 36
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [19:0]  angle,
   output logic                busy,
   output logic signed [31:0]  cos_out,
   output logic signed [31:0]  sin_out
);

   localparam int XW = 33;
   localparam logic signed [AW-1:0] PI_A      = AW'(ddo_pkg::Q30_PI);
   localparam logic signed [AW-1:0] HALF_PI_A = AW'(ddo_pkg::Q30_HALF_PI);
   localparam logic signed [AW-1:0] TWO_PI_A  = AW'(ddo_pkg::Q30_TWO_PI);
   localparam logic signed [XW-1:0] GAIN_X    = XW'(ddo_pkg::Q30_GAIN);
   localparam logic [4:0] LAST_STEP = 5'(ddo_pkg::CORDIC_STEPS - 1);

   typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ROT} cordic_state_type;

   cordic_state_type        state_ff, state_in;
   logic [4:0]              step_ff, step_in;
   logic signed [AW-1:0]    ang_ff, ang_in;
   logic signed [XW-1:0]    x_ff, x_in;
   logic signed [XW-1:0]    y_ff, y_in;
   logic                    flip_ff, flip_in;
   logic signed [XW-1:0]    x_sh, y_sh;
   logic signed [AW-1:0]    atan_a;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ang_in   = ang_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      flip_in  = flip_ff;
      x_sh     = x_ff >>> step_ff;
      y_sh     = y_ff >>> step_ff;
      atan_a   = AW'(ddo_pkg::atan_q30(step_ff));
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               ang_in   = AW'(angle) <<< (ddo_pkg::Q30_SHIFT - FRAC_BITS);
               x_in     = GAIN_X;
               y_in     = '0;
               flip_in  = 1'b0;
               step_in  = '0;
               state_in = C_RED;
            end
         end
         C_RED: begin
            // alternate the upper and lower bound checks, two passes each
            if (!step_ff[0]) begin
               if (ang_ff > PI_A) ang_in = ang_ff - TWO_PI_A;
            end else begin
               if (ang_ff < -PI_A) ang_in = ang_ff + TWO_PI_A;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd3) begin
               step_in  = '0;
               state_in = C_FOLD;
            end
         end
         C_FOLD: begin
            if (ang_ff > HALF_PI_A) begin
               ang_in  = ang_ff - PI_A;
               flip_in = 1'b1;
            end else if (ang_ff < -HALF_PI_A) begin
               ang_in  = ang_ff + PI_A;
               flip_in = 1'b1;
            end
            state_in = C_ROT;
         end
         C_ROT: begin
            if (ang_ff >= 0) begin
               x_in   = x_ff - y_sh;
               y_in   = y_ff + x_sh;
               ang_in = ang_ff - atan_a;
            end else begin
               x_in   = x_ff + y_sh;
               y_in   = y_ff - x_sh;
               ang_in = ang_ff + atan_a;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      ang_ff  <= ang_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      flip_ff <= flip_in;
   end

   assign busy    = state_ff != C_IDLE;
   assign cos_out = flip_ff ? 32'(-x_ff) : 32'(x_ff);
   assign sin_out = flip_ff ? 32'(-y_ff) : 32'(y_ff);

endmodule

@@ design/diff_drive_odometry.sv @@
// Differential-drive odometry: sequencer around a shared multiplier, divider and CORDIC.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | wheel rates, elapsed time
//   rsp     | out       | rsp_valid / rsp_ready  | pose, world velocity, yaw rate
//   csr     | in        | csr_valid / csr_ready  | register index, write data
//
// rsp_valid rises as the sequencer returns to idle, so the next transaction can be
// taken in that same cycle. Two wheel multiplies come first, then the CORDIC, then
// seven passes through the shared multiplier; the yaw divider runs beside the CORDIC
// and finishes before it is needed.
// req_ready is high only while the sequencer is idle; a finished result sits in
// the output register so the next transaction can be taken while it waits.
// A stalled rsp holds the sequencer before it overwrites the output register.
// Reset is synchronous; it restores the register defaults and zeroes the pose.
`include "diff_drive_odometry_defines.svh"

module diff_drive_odometry #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [23:0]                   req_left_wheel_rate,
   input  logic signed [23:0]                   req_right_wheel_rate,
   input  logic [15:0]                          req_elapsed_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_position_x,
   output logic signed [31:0]                   rsp_position_y,
   output logic signed [19:0]                   rsp_heading,
   output logic signed [31:0]                   rsp_world_velocity_x,
   output logic signed [31:0]                   rsp_world_velocity_y,
   output logic signed [31:0]                   rsp_yaw_rate,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ddo_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                          csr_data
);

   localparam int LW  = 42 - FRAC_BITS;
   localparam int MAW = (LW > 32) ? LW : 32;
   localparam int MBW = 32;
   localparam int PW  = MAW + MBW;
   localparam int ACW = PW + 1;
   localparam int NW  = LW + 1 + FRAC_BITS;
   localparam int DW  = 17;
   localparam int AW  = (52 - FRAC_BITS > 36) ? 52 - FRAC_BITS : 36;
   localparam int TW  = 32;

   localparam longint TWO_PI_FX =
      ((64'sd6283185307 << FRAC_BITS) + 64'sd500000000) / 64'sd1000000000;
   localparam longint RAD_RAW   = ((64'sd78 << FRAC_BITS) + 64'sd500) / 64'sd1000;
   localparam longint TRK_RAW   = ((64'sd2095 << FRAC_BITS) + 64'sd5000) / 64'sd10000;
   localparam logic [15:0] RADIUS_RESET = 16'((RAD_RAW > 65535) ? 65535 : RAD_RAW);
   localparam logic [15:0] TRACK_RESET  = 16'((TRK_RAW > 65535) ? 65535 : TRK_RAW);

   localparam logic signed [TW-1:0]  TP_T      = TW'(TWO_PI_FX);
   localparam logic signed [ACW-1:0] TP2_A     = ACW'(2 * TWO_PI_FX);
   localparam logic signed [ACW-1:0] MAX32_A   = ACW'(64'sh7FFF_FFFF);
   localparam logic signed [ACW-1:0] MIN32_A   = ACW'(-64'sh8000_0000);

   typedef enum logic [4:0] {
      S_IDLE, S_ML, S_MR, S_SUM, S_WAITC, S_M1, S_M2, S_M3, S_M4, S_M5,
      S_WVY, S_M6, S_M7, S_WAITD, S_HD, S_WRAP, S_DONE
   } seq_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACW-1:0] v);
      logic signed [31:0] r;
      if (v > MAX32_A) r = 32'sh7FFF_FFFF;
      else if (v < MIN32_A) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   seq_state_type          state_ff, state_in;
   logic [15:0]            radius_ff, radius_in;
   logic [15:0]            track_ff, track_in;
   logic signed [31:0]     lateral_ff, lateral_in;
   logic signed [24:0]     wl_ff, wl_in;
   logic signed [24:0]     wr_ff, wr_in;
   logic [15:0]            dt_ff, dt_in;
   logic signed [LW-1:0]   l_ff, l_in;
   logic signed [LW-1:0]   vx_ff, vx_in;
   logic signed [ACW-1:0]  acc_ff, acc_in;
   logic signed [31:0]     wvx_ff, wvx_in;
   logic signed [31:0]     wvy_ff, wvy_in;
   logic signed [TW-1:0]   th_ff, th_in;
   logic signed [31:0]     pose_x_ff, pose_x_in;
   logic signed [31:0]     pose_y_ff, pose_y_in;
   logic signed [19:0]     pose_heading_ff, pose_heading_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     rsp_x_ff, rsp_x_in;
   logic signed [31:0]     rsp_y_ff, rsp_y_in;
   logic signed [19:0]     rsp_heading_ff, rsp_heading_in;
   logic signed [31:0]     rsp_wvx_ff, rsp_wvx_in;
   logic signed [31:0]     rsp_wvy_ff, rsp_wvy_in;
   logic signed [31:0]     rsp_yaw_ff, rsp_yaw_in;

   logic signed [MAW-1:0]  mul_a;
   logic signed [MBW-1:0]  mul_b;
   logic signed [PW-1:0]   prod;
   logic signed [ACW-1:0]  prod_a;
   logic signed [ACW-1:0]  prod_fx;
   logic signed [LW-1:0]   r_cur;
   logic signed [LW:0]     lr_sum;
   logic signed [LW:0]     lr_diff;
   logic [LW:0]            diff_mag;
   logic                   div_start, div_busy;
   logic [NW-1:0]          div_dividend;
   logic [DW-1:0]          div_divisor;
   logic signed [31:0]     yaw;
   logic                   cor_start, cor_busy;
   logic signed [31:0]     cos_v, sin_v;
   logic signed [ACW-1:0]  sum_a;

   assign prod_a  = ACW'(prod);
   assign prod_fx = prod_a >>> FRAC_BITS;
   assign r_cur   = LW'(prod_fx);
   assign lr_sum  = (LW+1)'(l_ff) + (LW+1)'(r_cur);
   assign lr_diff = (LW+1)'(r_cur) - (LW+1)'(l_ff);
   assign diff_mag = lr_diff[LW] ? (LW+1)'(-lr_diff) : (LW+1)'(lr_diff);
   assign div_dividend = NW'(diff_mag) << FRAC_BITS;
   assign div_divisor  = (track_ff == '0) ? DW'(2) : {track_ff, 1'b0};
   assign div_start = state_ff == S_SUM;
   assign cor_start = state_ff == S_SUM;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_ML:    begin mul_a = MAW'(wl_ff);      mul_b = MBW'(radius_ff); end
         S_MR:    begin mul_a = MAW'(wr_ff);      mul_b = MBW'(radius_ff); end
         S_M1:    begin mul_a = MAW'(vx_ff);      mul_b = cos_v;           end
         S_M2:    begin mul_a = MAW'(lateral_ff); mul_b = sin_v;           end
         S_M3:    begin mul_a = MAW'(vx_ff);      mul_b = sin_v;           end
         S_M4:    begin mul_a = MAW'(lateral_ff); mul_b = cos_v;           end
         S_WVY:   begin mul_a = MAW'(wvx_ff);     mul_b = MBW'(dt_ff);     end
         S_M6:    begin mul_a = MAW'(wvy_ff);     mul_b = MBW'(dt_ff);     end
         S_WAITD: begin mul_a = MAW'(yaw);        mul_b = MBW'(dt_ff);     end
         default: begin mul_a = '0;               mul_b = '0;              end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      radius_in       = radius_ff;
      track_in        = track_ff;
      lateral_in      = lateral_ff;
      wl_in           = wl_ff;
      wr_in           = wr_ff;
      dt_in           = dt_ff;
      l_in            = l_ff;
      vx_in           = vx_ff;
      acc_in          = acc_ff;
      wvx_in          = wvx_ff;
      wvy_in          = wvy_ff;
      th_in           = th_ff;
      pose_x_in       = pose_x_ff;
      pose_y_in       = pose_y_ff;
      pose_heading_in = pose_heading_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_heading_in  = rsp_heading_ff;
      rsp_wvx_in      = rsp_wvx_ff;
      rsp_wvy_in      = rsp_wvy_ff;
      rsp_yaw_in      = rsp_yaw_ff;
      sum_a           = '0;

      if (csr_valid) begin
         if (csr_index == ddo_pkg::CSR_WHEEL_RADIUS) radius_in = csr_data[15:0];
         if (csr_index == ddo_pkg::CSR_HALF_TRACK) track_in = csr_data[15:0];
         if (csr_index == ddo_pkg::CSR_LATERAL_VELOCITY) lateral_in = $signed(csr_data);
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               wl_in    = -(25'(req_left_wheel_rate));
               wr_in    = -(25'(req_right_wheel_rate));
               dt_in    = req_elapsed_time;
               state_in = S_ML;
            end
         end
         S_ML: state_in = S_MR;
         S_MR: begin
            l_in     = r_cur;
            state_in = S_SUM;
         end
         S_SUM: begin
            vx_in    = LW'(lr_sum >>> 1);
            state_in = S_WAITC;
         end
         S_WAITC: if (!cor_busy) state_in = S_M1;
         S_M1: state_in = S_M2;
         S_M2: begin
            acc_in   = prod_a;
            state_in = S_M3;
         end
         S_M3: begin
            acc_in   = acc_ff - prod_a;
            state_in = S_M4;
         end
         S_M4: begin
            wvx_in   = sat32(acc_ff >>> ddo_pkg::Q30_SHIFT);
            acc_in   = prod_a;
            state_in = S_M5;
         end
         S_M5: begin
            acc_in   = acc_ff + prod_a;
            state_in = S_WVY;
         end
         S_WVY: begin
            wvy_in   = sat32(acc_ff >>> ddo_pkg::Q30_SHIFT);
            state_in = S_M6;
         end
         S_M6: begin
            sum_a     = ACW'(pose_x_ff) + prod_fx;
            pose_x_in = sat32(sum_a);
            state_in  = S_M7;
         end
         S_M7: begin
            sum_a     = ACW'(pose_y_ff) + prod_fx;
            pose_y_in = sat32(sum_a);
            state_in  = S_WAITD;
         end
         S_WAITD: if (!div_busy) state_in = S_HD;
         S_HD: begin
            // clamp the heading sum before the single wrap
            sum_a = ACW'(pose_heading_ff) + prod_fx;
            if (sum_a > TP2_A) th_in = TW'(TP2_A);
            else if (sum_a < -TP2_A) th_in = TW'(-TP2_A);
            else th_in = TW'(sum_a);
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (th_ff > TP_T) pose_heading_in = 20'(th_ff - TP_T);
            else if (th_ff < -TP_T) pose_heading_in = 20'(th_ff + TP_T);
            else pose_heading_in = 20'(th_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = pose_x_ff;
               rsp_y_in       = pose_y_ff;
               rsp_heading_in = pose_heading_ff;
               rsp_wvx_in     = wvx_ff;
               rsp_wvy_in     = wvy_ff;
               rsp_yaw_in     = yaw;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         radius_ff       <= RADIUS_RESET;
         track_ff        <= TRACK_RESET;
         lateral_ff      <= '0;
         pose_x_ff       <= '0;
         pose_y_ff       <= '0;
         pose_heading_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         radius_ff       <= radius_in;
         track_ff        <= track_in;
         lateral_ff      <= lateral_in;
         pose_x_ff       <= pose_x_in;
         pose_y_ff       <= pose_y_in;
         pose_heading_ff <= pose_heading_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      wl_ff          <= wl_in;
      wr_ff          <= wr_in;
      dt_ff          <= dt_in;
      l_ff           <= l_in;
      vx_ff          <= vx_in;
      acc_ff         <= acc_in;
      wvx_ff         <= wvx_in;
      wvy_ff         <= wvy_in;
      th_ff          <= th_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_wvx_ff     <= rsp_wvx_in;
      rsp_wvy_ff     <= rsp_wvy_in;
      rsp_yaw_ff     <= rsp_yaw_in;
   end

   ddo_mul #(.A_W(MAW), .B_W(MBW)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   ddo_div #(.NW(NW), .DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .negate   (lr_diff[LW]),
      .busy     (div_busy),
      .quotient (yaw)
   );

   ddo_cordic #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (pose_heading_ff),
      .busy    (cor_busy),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   assign req_ready            = state_ff == S_IDLE;
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position_x       = rsp_x_ff;
   assign rsp_position_y       = rsp_y_ff;
   assign rsp_heading          = rsp_heading_ff;
   assign rsp_world_velocity_x = rsp_wvx_ff;
   assign rsp_world_velocity_y = rsp_wvy_ff;
   assign rsp_yaw_rate         = rsp_yaw_ff;

   `DDO_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `DDO_ASSERT_NOW(a_units_idle_at_launch, state_ff == S_SUM, !cor_busy && !div_busy)
   `DDO_ASSERT_NOW(a_heading_wrapped, rsp_valid_ff && (FRAC_BITS <= 16),
      (rsp_heading_ff <= TP_T) && (rsp_heading_ff >= -TP_T))

endmodule
